### rtl/npc_pkg.sv
// Shared types and constants for the nearest palette color block.
// Used by npc_ctrl, npc_dpath and the top level; no dependencies of its own.
package npc_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int ADDR_W          = $clog2(PALETTE_ENTRIES);
    localparam int IDX_W           = 8;
    localparam int CHAN_W          = 8;
    localparam int COLOR_W         = 3 * CHAN_W;
    localparam int SQ_W            = 2 * CHAN_W;
    localparam int DIST_W          = 18;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_MATCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic write_entry;
        logic start_query;
        logic issue;
        logic load_out;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic addr_last;
        logic scan_done;
        logic out_busy;
    } t_dp_stat;

endpackage

### rtl/npc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module npc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/npc_ctrl.sv
// Sequencer for the nearest palette color block: accepts items, runs the scan,
// hands the result to the output register. Depends on npc_pkg.
module npc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_cmd,
    output logic              o_ready,
    output npc_pkg::t_dp_cmd  o_dp_cmd,
    input  npc_pkg::t_dp_stat i_dp_stat
);
    import npc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_cmd == CMD_MATCH) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_dp_stat.addr_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_dp_stat.scan_done) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!i_dp_stat.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_dp_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_dp_cmd.write_entry = accept && (i_cmd == CMD_WRITE);
                o_dp_cmd.start_query = accept && (i_cmd == CMD_MATCH);
            end
            ST_SCAN: begin
                o_dp_cmd.issue = 1'b1;
            end
            ST_DRAIN: begin
                o_dp_cmd = '0;
            end
            ST_RESULT: begin
                o_dp_cmd.load_out = !i_dp_stat.out_busy;
            end
            default: o_dp_cmd = '0;
        endcase
    end

endmodule

### rtl/npc_dpath.sv
// Datapath: palette RAM, scan address, distance pipeline, best-match tracking
// and output register. Depends on npc_pkg and npc_ram.
module npc_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  npc_pkg::t_dp_cmd            i_dp_cmd,
    output npc_pkg::t_dp_stat           o_dp_stat,
    input  logic [npc_pkg::IDX_W-1:0]   i_entry_index,
    input  logic [npc_pkg::CHAN_W-1:0]  i_red,
    input  logic [npc_pkg::CHAN_W-1:0]  i_green,
    input  logic [npc_pkg::CHAN_W-1:0]  i_blue,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [npc_pkg::IDX_W-1:0]   o_match_index
);
    import npc_pkg::*;

    localparam logic [IDX_W:0]  LIMIT    = (IDX_W + 1)'(PALETTE_ENTRIES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_ENTRIES - 1);

    // query color
    logic [CHAN_W-1:0] r_q_red, r_q_green, r_q_blue;

    // scan address
    logic [ADDR_W-1:0] r_addr;

    // stage 1: RAM read data
    logic              r_v1, r_first1, r_last1;
    logic [ADDR_W-1:0] r_idx1;
    logic [COLOR_W-1:0] rdata;

    // stage 2: squared differences
    logic              r_v2, r_first2, r_last2;
    logic [ADDR_W-1:0] r_idx2;
    logic [SQ_W-1:0]   r_sq_r, r_sq_g, r_sq_b;

    // stage 3: distance
    logic              r_v3, r_first3, r_last3;
    logic [ADDR_W-1:0] r_idx3;
    logic [DIST_W-1:0] r_dist;

    // best so far
    logic [DIST_W-1:0] r_best_dist;
    logic [ADDR_W-1:0] r_best_idx;

    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_idx;

    logic              we;
    logic [COLOR_W-1:0] wdata;
    logic [CHAN_W-1:0] d_r, d_g, d_b;
    logic [CHAN_W-1:0] e_r, e_g, e_b;

    // drop writes beyond the palette
    assign we    = i_dp_cmd.write_entry && ({1'b0, i_entry_index} < LIMIT);
    assign wdata = {i_red, i_green, i_blue};

    npc_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_entry_index[ADDR_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    assign e_b = rdata[CHAN_W-1:0];
    assign e_g = rdata[2*CHAN_W-1:CHAN_W];
    assign e_r = rdata[3*CHAN_W-1:2*CHAN_W];

    assign d_r = (e_r > r_q_red)   ? (e_r - r_q_red)   : (r_q_red - e_r);
    assign d_g = (e_g > r_q_green) ? (e_g - r_q_green) : (r_q_green - e_g);
    assign d_b = (e_b > r_q_blue)  ? (e_b - r_q_blue)  : (r_q_blue - e_b);

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.start_query) begin
            r_q_red   <= i_red;
            r_q_green <= i_green;
            r_q_blue  <= i_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_dp_cmd.start_query) begin
            r_addr <= '0;
        end else if (i_dp_cmd.issue && r_addr != LAST_ADDR) begin
            r_addr <= r_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_dp_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first1 <= (r_addr == '0);
        r_last1  <= (r_addr == LAST_ADDR);
        r_idx1   <= r_addr;

        r_first2 <= r_first1;
        r_last2  <= r_last1;
        r_idx2   <= r_idx1;
        r_sq_r   <= d_r * d_r;
        r_sq_g   <= d_g * d_g;
        r_sq_b   <= d_b * d_b;

        r_first3 <= r_first2;
        r_last3  <= r_last2;
        r_idx3   <= r_idx2;
        r_dist   <= DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);
    end

    // strict less-than keeps the lowest index on a tie
    always_ff @(posedge i_clk) begin
        if (r_v3 && (r_first3 || r_dist < r_best_dist)) begin
            r_best_dist <= r_dist;
            r_best_idx  <= r_idx3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_dp_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load_out) begin
            r_out_idx <= IDX_W'(r_best_idx);
        end
    end

    assign o_dp_stat.addr_last = i_dp_cmd.issue && (r_addr == LAST_ADDR);
    assign o_dp_stat.scan_done = r_v3 && r_last3;
    assign o_dp_stat.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_match_index = r_out_idx;

endmodule

### rtl/nearest_palette_color.sv
// Top level of the nearest palette color block.
// Depends on npc_pkg, npc_ctrl, npc_dpath (which holds npc_ram).
//
// Holds a palette of PALETTE_ENTRIES colors in a single-port-read RAM. A write
// item (cmd = 0) loads one entry and returns nothing; writes to indexes beyond
// the palette are dropped. A match item (cmd = 1) scans every entry from
// index 0, one RAM read per cycle, forms the squared Euclidean distance to
// the query color and returns the index of the smallest one, the lowest
// index on a tie. A match occupies the block while the palette RAM is read,
// the three-stage distance pipeline drains and the result is handed to the
// output register; the block takes no new item until then. Entries must be
// loaded before they are matched against: the palette RAM is not cleared at
// reset.
module nearest_palette_color (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_cmd,
    input  logic [npc_pkg::IDX_W-1:0]  i_entry_index,
    input  logic [npc_pkg::CHAN_W-1:0] i_red,
    input  logic [npc_pkg::CHAN_W-1:0] i_green,
    input  logic [npc_pkg::CHAN_W-1:0] i_blue,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [npc_pkg::IDX_W-1:0]  o_match_index
);
    import npc_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    npc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_cmd     (i_cmd),
        .o_ready   (o_ready),
        .o_dp_cmd  (dp_cmd),
        .i_dp_stat (dp_stat)
    );

    npc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp_cmd      (dp_cmd),
        .o_dp_stat     (dp_stat),
        .i_entry_index (i_entry_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_out_ready   (i_ready),
        .o_out_valid   (o_valid),
        .o_match_index (o_match_index)
    );

endmodule
